// ===== rtl/color_palette_builder_top_macros.svh =====
// Assertion macros for the color palette builder top level.
// Included by color_palette_builder_top.sv; no other dependencies.
`ifndef COLOR_PALETTE_BUILDER_TOP_MACROS_SVH
`define COLOR_PALETTE_BUILDER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CPB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpb: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define CPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpb: next-cycle check failed");

`endif

// ===== rtl/cpb_pkg.sv =====
// Shared types and constants for the color palette builder.
// No dependencies; used by the cell, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package cpb_pkg;

  // Palette depth and derived widths
  localparam int PALETTE_ENTRIES = 256;
  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
  localparam int RD_IDX_W = 8;
  localparam int CMP_W = (IDX_W > RD_IDX_W) ? IDX_W : RD_IDX_W;
  localparam int COLOR_W = 24;
  localparam int CH_W = 8;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  // Request token that walks down the cell chain
  typedef struct packed {
    logic                vld;
    action_e             action;
    logic [COLOR_W-1:0]  color;
    logic [RD_IDX_W-1:0] rd_idx;
    logic [CNT_W-1:0]    count;
    logic                found;
    logic                added;
    logic [IDX_W-1:0]    found_idx;
    logic [COLOR_W-1:0]  rd_color;
  } token_t;

endpackage

`default_nettype wire

// ===== rtl/cpb_ifs.sv =====
// Valid/ready channel interfaces for pixel requests and lookup results.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cpb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic [7:0] entry_index;

  modport source (output valid, action, pixel_red, pixel_green, pixel_blue, entry_index,
                  input ready);
  modport sink   (input valid, action, pixel_red, pixel_green, pixel_blue, entry_index,
                  output ready);
endinterface

interface cpb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] match_index;
  logic       hit;
  logic       added;
  logic       table_full;
  logic [8:0] color_count;
  logic [7:0] read_red;
  logic [7:0] read_green;
  logic [7:0] read_blue;

  modport source (output valid, match_index, hit, added, table_full, color_count,
                  read_red, read_green, read_blue, input ready);
  modport sink   (input valid, match_index, hit, added, table_full, color_count,
                  read_red, read_green, read_blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/cpb_cell.sv =====
// One palette cell: holds one color entry, checks the passing token and forwards it.
// Depends on cpb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpb_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [cpb_pkg::IDX_W-1:0]  cell_idx_i,
  input  wire cpb_pkg::token_t            tok_i,
  output cpb_pkg::token_t                 tok_o
);

  logic [cpb_pkg::COLOR_W-1:0] color_q;
  cpb_pkg::token_t             tok_d;
  cpb_pkg::token_t             tok_q;
  logic                        in_use;
  logic                        is_lookup;
  logic                        wr_en;

  // This entry is live when its position is below the current fill count
  assign in_use    = cpb_pkg::CNT_W'(cell_idx_i) < tok_i.count;
  assign is_lookup = (tok_i.action == cpb_pkg::ACT_INSERT) ||
                     (tok_i.action == cpb_pkg::ACT_FIND);
  // Append lands in the first free entry once no earlier entry matched
  assign wr_en     = tok_i.vld && (tok_i.action == cpb_pkg::ACT_INSERT) && !tok_i.found &&
                     (cpb_pkg::CNT_W'(cell_idx_i) == tok_i.count);

  // Update the token as it passes this entry
  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && in_use) begin
      if (is_lookup && !tok_i.found && (color_q == tok_i.color)) begin
        tok_d.found     = 1'b1;
        tok_d.found_idx = cell_idx_i;
      end
      if ((tok_i.action == cpb_pkg::ACT_READ) &&
          (cpb_pkg::CMP_W'(cell_idx_i) == cpb_pkg::CMP_W'(tok_i.rd_idx))) begin
        tok_d.rd_color = color_q;
      end
    end
    if (wr_en) begin
      tok_d.found     = 1'b1;
      tok_d.added     = 1'b1;
      tok_d.found_idx = cell_idx_i;
    end
  end

  // Entry storage, written once per append
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      color_q <= tok_i.color;
    end
  end

  // Token stage toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== rtl/color_palette_builder_top.sv =====
// Color palette builder top level: request control, cell chain and result register.
// Depends on cpb_pkg, cpb_ifs, cpb_cell and color_palette_builder_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Collects distinct 24-bit colors in first-seen order in a row of PALETTE_ENTRIES
// cells, one entry per cell. Each request travels the whole row, one cell per
// clock, and its result is registered as the token leaves the last cell.
// One request is in flight at a time: the input channel stays not-ready from a
// transfer until its result has been taken, so the block takes no new request
// before it is through with the last one. Insert appends a new color, reports
// the index of a stored one or flags a full table, find only looks up, read
// returns the entry at an index (black past the fill count), and clear empties
// the table. No clearing pass is needed after reset.
`include "color_palette_builder_top_macros.svh"

module color_palette_builder_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cpb_in_if.sink     in_i,
  cpb_out_if.source  out_o
);

  localparam int N = cpb_pkg::PALETTE_ENTRIES;

  logic                      busy_q, busy_d;
  logic                      out_vld_q, out_vld_d;
  logic [cpb_pkg::CNT_W-1:0] count_q, count_d;
  logic                      in_xfer;
  logic                      out_xfer;
  cpb_pkg::token_t           tok_head;
  cpb_pkg::token_t           chain [N+1];
  cpb_pkg::token_t           tok_tail;
  logic [31:0]               idx_wide;
  logic [31:0]               cnt_wide;

  logic [7:0]                match_index_q, match_index_d;
  logic                      hit_q, hit_d;
  logic                      added_q, added_d;
  logic                      full_q, full_d;
  logic [8:0]                color_count_q, color_count_d;
  logic [cpb_pkg::COLOR_W-1:0] rd_color_q, rd_color_d;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign in_i.ready = !busy_q;

  // Build the token that enters the first cell
  always_comb begin
    tok_head           = '0;
    tok_head.vld       = in_xfer;
    tok_head.action    = cpb_pkg::action_e'(in_i.action);
    tok_head.color     = {in_i.pixel_red, in_i.pixel_green, in_i.pixel_blue};
    tok_head.rd_idx    = in_i.entry_index;
    tok_head.count     = count_q;
  end

  assign chain[0] = tok_head;

  // Row of palette cells
  for (genvar g = 0; g < N; g++) begin : g_cell
    cpb_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (cpb_pkg::IDX_W'(g)),
      .tok_i      (chain[g]),
      .tok_o      (chain[g+1])
    );
  end

  assign tok_tail = chain[N];

  // Result formation when the token leaves the row
  always_comb begin
    idx_wide      = 32'(tok_tail.found_idx);
    count_d       = count_q;
    match_index_d = match_index_q;
    hit_d         = hit_q;
    added_d       = added_q;
    full_d        = full_q;
    rd_color_d    = rd_color_q;
    if (tok_tail.vld) begin
      unique case (tok_tail.action)
        cpb_pkg::ACT_CLEAR: count_d = '0;
        cpb_pkg::ACT_INSERT: begin
          if (tok_tail.added) begin
            count_d = count_q + 1'b1;
          end
        end
        cpb_pkg::ACT_FIND,
        cpb_pkg::ACT_READ: count_d = count_q;
        default: count_d = count_q;
      endcase
      match_index_d = tok_tail.found ? idx_wide[7:0] : 8'd0;
      hit_d         = tok_tail.found && !tok_tail.added;
      added_d       = tok_tail.added;
      full_d        = (tok_tail.action == cpb_pkg::ACT_INSERT) && !tok_tail.found;
      rd_color_d    = tok_tail.rd_color;
    end
    cnt_wide      = 32'(count_d);
    color_count_d = tok_tail.vld ? cnt_wide[8:0] : color_count_q;
  end

  // Control: busy from input transfer until the result transfer
  always_comb begin
    busy_d    = busy_q;
    out_vld_d = out_vld_q;
    if (in_xfer) begin
      busy_d = 1'b1;
    end
    if (tok_tail.vld) begin
      out_vld_d = 1'b1;
    end
    if (out_xfer) begin
      out_vld_d = 1'b0;
      busy_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
      count_q   <= '0;
    end else begin
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
      count_q   <= count_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    match_index_q <= match_index_d;
    hit_q         <= hit_d;
    added_q       <= added_d;
    full_q        <= full_d;
    color_count_q <= color_count_d;
    rd_color_q    <= rd_color_d;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.match_index = match_index_q;
  assign out_o.hit         = hit_q;
  assign out_o.added       = added_q;
  assign out_o.table_full  = full_q;
  assign out_o.color_count = color_count_q;
  assign out_o.read_red    = rd_color_q[23:16];
  assign out_o.read_green  = rd_color_q[15:8];
  assign out_o.read_blue   = rd_color_q[7:0];

  // Checks
  `CPB_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_xfer, busy_q)
  `CPB_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, 32'(count_q) <= 32'(N))
  `CPB_ASSERT_NOW(a_out_while_busy, clk_i, rst_ni, out_vld_q, busy_q)
  `CPB_ASSERT_NOW(a_tail_single, clk_i, rst_ni, tok_tail.vld, busy_q && !out_vld_q)

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for color_palette_builder_top: a palette tracker class predicts
// every lookup result and checks what comes back. Directed requests and random pixel streams drive the block.
// Depends on cpb_pkg, cpb_ifs and the color_palette_builder_top RTL.

module testbench;

  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_ITEMS = 1700;
  localparam int DRAIN_CYCLES = cpb_pkg::PALETTE_ENTRIES + 16;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int MAX_STALL    = 8;

  typedef struct packed {
    cpb_pkg::action_e action;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       index;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] match_index;
    logic       hit;
    logic       added;
    logic       table_full;
    logic [8:0] color_count;
    logic [7:0] read_red;
    logic [7:0] read_green;
    logic [7:0] read_blue;
  } lookup_res_t;

  // Mirror of the palette contents plus the queue of lookups still in flight
  class palette_tracker;
    logic [23:0] held_colors [cpb_pkg::PALETTE_ENTRIES];
    int          held_count;
    lookup_res_t pending_lookups [$];
    int unsigned mismatches;

    function new();
      held_count = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return pending_lookups.size();
    endfunction

    // Applies one request to the mirror and returns the result it must produce
    function lookup_res_t predict_lookup(pixel_req_t p);
      lookup_res_t res;
      logic [23:0] color;
      int          where;
      int          k;
      bit          found;
      res   = '0;
      color = {p.red, p.green, p.blue};
      found = 1'b0;
      where = 0;
      // all three channels take part in the match
      if (p.action == cpb_pkg::ACT_INSERT || p.action == cpb_pkg::ACT_FIND) begin
        for (k = 0; k < held_count && !found; k++) begin
          if (held_colors[k] == color) begin
            found = 1'b1;
            where = k;
          end
        end
      end
      case (p.action)
        cpb_pkg::ACT_CLEAR: begin
          held_count = 0;
        end
        cpb_pkg::ACT_INSERT: begin
          if (found) begin
            res.hit         = 1'b1;
            res.match_index = 8'(where);
          end else if (held_count < cpb_pkg::PALETTE_ENTRIES) begin
            held_colors[held_count] = color;
            res.match_index = 8'(held_count);
            res.added       = 1'b1;
            held_count++;
          end else begin
            res.table_full = 1'b1;
          end
        end
        cpb_pkg::ACT_FIND: begin
          if (found) begin
            res.hit         = 1'b1;
            res.match_index = 8'(where);
          end
        end
        cpb_pkg::ACT_READ: begin
          // past the fill count reads black
          if (p.index < held_count)
            {res.read_red, res.read_green, res.read_blue} = held_colors[p.index];
        end
      endcase
      res.color_count = 9'(held_count);
      return res;
    endfunction

    function void note_pixel(pixel_req_t p);
      pending_lookups.push_back(predict_lookup(p));
    endfunction

    function void check_field(string name, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
        mismatches++;
        $display("t=%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_lookup(lookup_res_t got);
      lookup_res_t want;
      if (pending_lookups.size() == 0) begin
        mismatches++;
        $display("t=%0t: result transfer expected none, got match_index %0d count %0d",
                 $time, got.match_index, got.color_count);
        return;
      end
      want = pending_lookups.pop_front();
      check_field("match_index", 9'(want.match_index), 9'(got.match_index));
      check_field("hit",         9'(want.hit),         9'(got.hit));
      check_field("added",       9'(want.added),       9'(got.added));
      check_field("table_full",  9'(want.table_full),  9'(got.table_full));
      check_field("color_count", want.color_count,     got.color_count);
      check_field("read_red",    9'(want.read_red),    9'(got.read_red));
      check_field("read_green",  9'(want.read_green),  9'(got.read_green));
      check_field("read_blue",   9'(want.read_blue),   9'(got.read_blue));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  cpb_in_if  pix_if ();
  cpb_out_if res_if ();

  color_palette_builder_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pix_if),
    .out_o  (res_if)
  );

  palette_tracker tracker;
  int             burst_left;
  int             items_sent;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** color_palette_builder_top: FAILED **");
    $finish;
  end

  function automatic logic [23:0] random_color();
    int unsigned r;
    r = $urandom();
    return r[23:0];
  endfunction

  function automatic logic [7:0] random_index();
    int unsigned r;
    r = $urandom_range(0, 255);
    return r[7:0];
  endfunction

  function automatic logic [23:0] known_color();
    int unsigned k;
    if (tracker.held_count == 0) return random_color();
    k = $urandom_range(0, tracker.held_count - 1);
    return tracker.held_colors[k];
  endfunction

  function automatic logic [7:0] held_index();
    int unsigned k;
    if (tracker.held_count == 0) return random_index();
    k = $urandom_range(0, tracker.held_count - 1);
    return k[7:0];
  endfunction

  function automatic pixel_req_t make_pixel(cpb_pkg::action_e a, logic [23:0] c,
                                            logic [7:0] idx);
    pixel_req_t p;
    p.action = a;
    {p.red, p.green, p.blue} = c;
    p.index = idx;
    return p;
  endfunction

  // One input transfer; bursts of random length with idle gaps between them.
  // Long gaps land around the point where the block turns ready again.
  task automatic send_pixel(input pixel_req_t p);
    int unsigned gap;
    if (burst_left == 0) begin
      pix_if.valid <= 1'b0;
      if ($urandom_range(0, 9) < 7) gap = $urandom_range(1, 6);
      else gap = $urandom_range(200, 300);
      if ($urandom_range(0, 4) == 0) burst_left = 80;
      else burst_left = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    pix_if.valid       <= 1'b1;
    pix_if.action      <= p.action;
    pix_if.pixel_red   <= p.red;
    pix_if.pixel_green <= p.green;
    pix_if.pixel_blue  <= p.blue;
    pix_if.entry_index <= p.index;
    do @(posedge clk_i); while (!pix_if.ready);
    tracker.note_pixel(p);
    items_sent++;
  endtask

  task automatic run_directed();
    send_pixel(make_pixel(cpb_pkg::ACT_READ,   24'h000000, 8'd0));   // read on empty table
    send_pixel(make_pixel(cpb_pkg::ACT_FIND,   24'hffffff, 8'hff));  // find miss when empty
    send_pixel(make_pixel(cpb_pkg::ACT_INSERT, 24'h000000, 8'hff));
    send_pixel(make_pixel(cpb_pkg::ACT_INSERT, 24'hffffff, 8'h00));
    send_pixel(make_pixel(cpb_pkg::ACT_INSERT, 24'h000000, 8'h00));  // hit on entry 0
    send_pixel(make_pixel(cpb_pkg::ACT_INSERT, 24'hff0000, 8'h00));
    send_pixel(make_pixel(cpb_pkg::ACT_INSERT, 24'h00ff00, 8'h00));
    send_pixel(make_pixel(cpb_pkg::ACT_INSERT, 24'h0000ff, 8'h00));
    send_pixel(make_pixel(cpb_pkg::ACT_INSERT, 24'h123456, 8'h00));
    // blue equal to the stored green must not match
    send_pixel(make_pixel(cpb_pkg::ACT_FIND,   24'h123434, 8'h00));
    send_pixel(make_pixel(cpb_pkg::ACT_FIND,   24'h123456, 8'h00));
    send_pixel(make_pixel(cpb_pkg::ACT_FIND,   24'h0000ff, 8'h00));
    send_pixel(make_pixel(cpb_pkg::ACT_FIND,   24'h000001, 8'h00));
    send_pixel(make_pixel(cpb_pkg::ACT_READ,   24'h000000, 8'd1));
    send_pixel(make_pixel(cpb_pkg::ACT_READ,   24'hffffff, 8'd5));   // last valid entry
    send_pixel(make_pixel(cpb_pkg::ACT_READ,   24'h000000, 8'd6));   // just past the count
    send_pixel(make_pixel(cpb_pkg::ACT_READ,   24'h000000, 8'd255));
    send_pixel(make_pixel(cpb_pkg::ACT_CLEAR,  24'hffffff, 8'hff));
    send_pixel(make_pixel(cpb_pkg::ACT_READ,   24'h000000, 8'd0));
    send_pixel(make_pixel(cpb_pkg::ACT_FIND,   24'h000000, 8'd0));
    send_pixel(make_pixel(cpb_pkg::ACT_INSERT, 24'ha5a5a5, 8'h5a));
    send_pixel(make_pixel(cpb_pkg::ACT_INSERT, 24'h5a5a5a, 8'ha5));
    send_pixel(make_pixel(cpb_pkg::ACT_READ,   24'h000000, 8'd0));
  endtask

  // Clear, fill every entry, push against the full table, then sometimes clear again
  task automatic run_fill_phase();
    int unsigned sel;
    send_pixel(make_pixel(cpb_pkg::ACT_CLEAR, random_color(), random_index()));
    while (tracker.held_count < cpb_pkg::PALETTE_ENTRIES) begin
      sel = $urandom_range(0, 99);
      if (sel < 85)
        send_pixel(make_pixel(cpb_pkg::ACT_INSERT, random_color(), random_index()));
      else if (sel < 92)
        send_pixel(make_pixel(cpb_pkg::ACT_INSERT, known_color(), random_index()));
      else if (sel < 96)
        send_pixel(make_pixel(cpb_pkg::ACT_FIND, known_color(), random_index()));
      else
        send_pixel(make_pixel(cpb_pkg::ACT_READ, random_color(), held_index()));
    end
    repeat (24) begin
      sel = $urandom_range(0, 99);
      if (sel < 40)
        send_pixel(make_pixel(cpb_pkg::ACT_INSERT, random_color(), random_index()));
      else if (sel < 55)
        send_pixel(make_pixel(cpb_pkg::ACT_INSERT, known_color(), random_index()));
      else if (sel < 75)
        send_pixel(make_pixel(cpb_pkg::ACT_FIND, known_color(), random_index()));
      else
        send_pixel(make_pixel(cpb_pkg::ACT_READ, random_color(), random_index()));
    end
    if ($urandom_range(0, 1) == 0)
      send_pixel(make_pixel(cpb_pkg::ACT_CLEAR, random_color(), random_index()));
  endtask

  // Mixed traffic: stored colors, one-bit near misses, fresh colors and noise
  task automatic run_mixed_phase(input int len);
    int unsigned sel;
    int unsigned csel;
    int unsigned r;
    logic [23:0] color;
    logic [7:0]  idx;
    repeat (len) begin
      csel = $urandom_range(0, 99);
      if (tracker.held_count > 0 && csel < 50) color = known_color();
      else if (tracker.held_count > 0 && csel < 65)
        color = known_color() ^ (24'h1 << $urandom_range(0, 23));
      else color = random_color();
      if ($urandom_range(0, 9) < 7) idx = held_index();
      else idx = random_index();
      sel = $urandom_range(0, 99);
      if (sel < 45)      send_pixel(make_pixel(cpb_pkg::ACT_INSERT, color, idx));
      else if (sel < 65) send_pixel(make_pixel(cpb_pkg::ACT_FIND, color, idx));
      else if (sel < 88) send_pixel(make_pixel(cpb_pkg::ACT_READ, color, idx));
      else if (sel < 91) send_pixel(make_pixel(cpb_pkg::ACT_CLEAR, color, idx));
      else begin
        r = $urandom();
        send_pixel(make_pixel(cpb_pkg::action_e'(r[1:0]), random_color(), random_index()));
      end
    end
  endtask

  // Stimulus
  initial begin
    int target;
    tracker    = new();
    burst_left = 0;
    items_sent = 0;
    rst_ni             <= 1'b0;
    pix_if.valid       <= 1'b0;
    pix_if.action      <= cpb_pkg::ACT_CLEAR;
    pix_if.pixel_red   <= '0;
    pix_if.pixel_green <= '0;
    pix_if.pixel_blue  <= '0;
    pix_if.entry_index <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    // hold off until every pending lookup has returned
    pix_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);

    target = items_sent + RANDOM_ITEMS;
    run_fill_phase();
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) run_fill_phase();
      else run_mixed_phase($urandom_range(20, 150));
      if ($urandom_range(0, 3) == 0) begin
        pix_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk_i);
      end
    end

    pix_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("** color_palette_builder_top: PASSED **");
    else
      $display("** color_palette_builder_top: FAILED **");
    $finish;
  end

  // Result side: check each transfer, stall the ready line on a changing pattern
  initial begin
    lookup_res_t got;
    int unsigned stall_left;
    int unsigned cyc;
    res_if.ready <= 1'b0;
    stall_left = 0;
    cyc        = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (rst_ni && res_if.valid && res_if.ready) begin
        got.match_index = res_if.match_index;
        got.hit         = res_if.hit;
        got.added       = res_if.added;
        got.table_full  = res_if.table_full;
        got.color_count = res_if.color_count;
        got.read_red    = res_if.read_red;
        got.read_green  = res_if.read_green;
        got.read_blue   = res_if.read_blue;
        tracker.check_lookup(got);
      end
      case ((cyc >> 12) % 4)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= (cyc % 3 == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
          end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, MAX_STALL - 1);
            res_if.ready <= 1'b0;
          end else begin
            res_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

endmodule
